### hw/rtl/wkbp_pkg.sv
package wkbp_pkg;

	// Default depth of the result queue; it must hold at least two words.
	localparam int RES_FIFO_DEPTH_DEF = 4;

	// Byte order mark for little-endian encoding.
	localparam logic [7:0] BYTE_ORDER_LE = 8'h01;

	// Bit of the type field that announces an SRID.
	localparam int SRID_FLAG_BIT = 29;

	// Geometry type codes.
	localparam logic [2:0] GT_NONE       = 3'd0;
	localparam logic [2:0] GT_POINT      = 3'd1;
	localparam logic [2:0] GT_LINE       = 3'd2;
	localparam logic [2:0] GT_POLYGON    = 3'd3;
	localparam logic [2:0] GT_MULTILINE  = 3'd5;
	localparam logic [2:0] GT_MULTIPOLY  = 3'd6;

	// Event codes of a result word.
	localparam logic [1:0] EV_HEADER   = 2'd0;
	localparam logic [1:0] EV_POINT    = 2'd1;
	localparam logic [1:0] EV_COMPLETE = 2'd2;
	localparam logic [1:0] EV_ERROR    = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_BYTE_ORDER  = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN     = 2'd1;
	localparam logic [1:0] ERR_NESTED_TYPE = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED   = 2'd3;

	// Parse phases.
	typedef enum logic [3:0] {
		PH_TOP_ORDER,
		PH_TOP_TYPE,
		PH_TOP_SRID,
		PH_SUB_ORDER,
		PH_SUB_TYPE,
		PH_SUB_SRID,
		PH_PART_COUNT,
		PH_RING_COUNT,
		PH_POINT_COUNT,
		PH_X,
		PH_Y,
		PH_IDLE
	} phase_t;

	// Input word: one byte of the buffer.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} src_word_t;

	// Result word.
	typedef struct packed {
		logic [1:0]         event_res;
		logic [2:0]         geometry_type;
		logic signed [31:0] srid_value;
		logic [63:0]        x_bits;
		logic [63:0]        y_bits;
		logic [31:0]        part_index;
		logic [31:0]        ring_index;
		logic [31:0]        point_index;
		logic [1:0]         error_code;
		logic               last_of_run;
	} res_word_t;

	// Up to two result words produced by one input byte, in order.
	typedef struct packed {
		logic [1:0]            count;
		res_word_t [1:0]       item;
	} res_push_t;

endpackage

### hw/rtl/wkbp_parse.sv
module wkbp_parse import wkbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      proc,
	input  src_word_t in_word,
	output res_push_t res
);

	phase_t      phase_q, phase_d;
	logic [2:0]  bif_q, bif_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] held_x_q, held_x_d;
	logic [2:0]  top_type_q, top_type_d;
	logic [31:0] top_srid_q, top_srid_d;
	logic [31:0] parts_left_q, parts_left_d;
	logic [31:0] rings_left_q, rings_left_d;
	logic [31:0] points_left_q, points_left_d;
	logic [31:0] part_ctr_q, part_ctr_d;
	logic [31:0] ring_ctr_q, ring_ctr_d;
	logic [31:0] point_ctr_q, point_ctr_d;
	logic        finished_q, finished_d;

	logic [63:0] v;
	logic [31:0] w;
	logic [15:0] tcode;
	logic [2:0]  req_type;
	logic        field_last;
	logic        e_point, e_header, e_eob;
	logic        do_fail, do_complete, do_eol, do_eop;
	logic [1:0]  fail_code;
	logic [2:0]  em_type;
	logic [31:0] em_srid;
	logic [1:0]  n;

	// True for the type codes that the parser accepts.
	function automatic logic known_type(input logic [15:0] t);
		return t == 16'(GT_POINT) || t == 16'(GT_LINE) || t == 16'(GT_POLYGON) ||
			t == 16'(GT_MULTILINE) || t == 16'(GT_MULTIPOLY);
	endfunction

	// First body phase of a geometry of the given type.
	function automatic phase_t body_phase(input logic [2:0] t);
		phase_t p;
		case (t)
			GT_POINT:   p = PH_X;
			GT_LINE:    p = PH_POINT_COUNT;
			GT_POLYGON: p = PH_RING_COUNT;
			default:    p = PH_PART_COUNT;
		endcase
		return p;
	endfunction

	function automatic res_word_t mk_res(input logic [1:0] ev, input logic [2:0] ty,
		input logic [31:0] sr, input logic [63:0] x, input logic [63:0] y,
		input logic [31:0] pi, input logic [31:0] ri, input logic [31:0] qi,
		input logic [1:0] ec);
		res_word_t r;
		r.event_res     = ev;
		r.geometry_type = ty;
		r.srid_value    = sr;
		r.x_bits        = x;
		r.y_bits        = y;
		r.part_index    = pi;
		r.ring_index    = ri;
		r.point_index   = qi;
		r.error_code    = ec;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	// Byte assembly, field decode and the result words of one byte.
	always_comb begin
		phase_d       = phase_q;
		bif_d         = bif_q;
		acc_d         = acc_q;
		held_x_d      = held_x_q;
		top_type_d    = top_type_q;
		top_srid_d    = top_srid_q;
		parts_left_d  = parts_left_q;
		rings_left_d  = rings_left_q;
		points_left_d = points_left_q;
		part_ctr_d    = part_ctr_q;
		ring_ctr_d    = ring_ctr_q;
		point_ctr_d   = point_ctr_q;
		finished_d    = finished_q;

		v        = acc_q | (64'(in_word.data_byte) << {bif_q, 3'b000});
		w        = v[31:0];
		tcode    = w[15:0];
		req_type = (top_type_q == GT_MULTILINE) ? GT_LINE : GT_POLYGON;

		case (phase_q)
			PH_TOP_ORDER, PH_SUB_ORDER: field_last = 1'b1;
			PH_X, PH_Y:                 field_last = (bif_q == 3'd7);
			default:                    field_last = (bif_q == 3'd3);
		endcase

		e_point     = 1'b0;
		e_header    = 1'b0;
		e_eob       = 1'b0;
		do_fail     = 1'b0;
		do_complete = 1'b0;
		do_eol      = 1'b0;
		do_eop      = 1'b0;
		fail_code   = ERR_BYTE_ORDER;

		if (proc && !finished_q && phase_q != PH_IDLE) begin
			if (!field_last) begin
				bif_d = bif_q + 3'd1;
				acc_d = v;
			end else begin
				bif_d = '0;
				acc_d = '0;
				case (phase_q)
					PH_TOP_ORDER, PH_SUB_ORDER: begin
						if (v[7:0] != BYTE_ORDER_LE) begin
							do_fail   = 1'b1;
							fail_code = ERR_BYTE_ORDER;
						end else begin
							phase_d = (phase_q == PH_TOP_ORDER) ? PH_TOP_TYPE : PH_SUB_TYPE;
						end
					end
					PH_TOP_TYPE: begin
						if (!known_type(tcode)) begin
							do_fail   = 1'b1;
							fail_code = ERR_UNKNOWN;
						end else begin
							top_type_d = tcode[2:0];
							if (w[SRID_FLAG_BIT]) begin
								phase_d = PH_TOP_SRID;
							end else begin
								e_header = 1'b1;
								phase_d  = body_phase(tcode[2:0]);
							end
						end
					end
					PH_TOP_SRID: begin
						top_srid_d = w;
						e_header   = 1'b1;
						phase_d    = body_phase(top_type_q);
					end
					PH_SUB_TYPE: begin
						if (tcode != 16'(req_type)) begin
							do_fail   = 1'b1;
							fail_code = known_type(tcode) ? ERR_NESTED_TYPE : ERR_UNKNOWN;
						end else if (w[SRID_FLAG_BIT]) begin
							phase_d = PH_SUB_SRID;
						end else begin
							phase_d = body_phase(req_type);
						end
					end
					PH_SUB_SRID: begin
						// A nested SRID is read and dropped.
						phase_d = body_phase(req_type);
					end
					PH_PART_COUNT: begin
						parts_left_d = w;
						part_ctr_d   = '0;
						if (w == '0) begin
							do_complete = 1'b1;
						end else begin
							phase_d = PH_SUB_ORDER;
						end
					end
					PH_RING_COUNT: begin
						rings_left_d = w;
						ring_ctr_d   = '0;
						if (w == '0) begin
							do_eop = 1'b1;
						end else begin
							phase_d = PH_POINT_COUNT;
						end
					end
					PH_POINT_COUNT: begin
						points_left_d = w;
						point_ctr_d   = '0;
						if (w == '0) begin
							do_eol = 1'b1;
						end else begin
							phase_d = PH_X;
						end
					end
					PH_X: begin
						held_x_d = v;
						phase_d  = PH_Y;
					end
					PH_Y: begin
						e_point = 1'b1;
						if (top_type_q == GT_POINT) begin
							do_complete = 1'b1;
						end else begin
							point_ctr_d   = point_ctr_q + 32'd1;
							points_left_d = points_left_q - 32'd1;
							if (points_left_q == 32'd1) begin
								do_eol = 1'b1;
							end else begin
								phase_d = PH_X;
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end

		// End of a line or ring: polygons count rings down.
		if (do_eol) begin
			if (top_type_q == GT_POLYGON || top_type_q == GT_MULTIPOLY) begin
				ring_ctr_d   = ring_ctr_q + 32'd1;
				rings_left_d = rings_left_q - 32'd1;
				if (rings_left_q == 32'd1) begin
					do_eop = 1'b1;
				end else begin
					phase_d = PH_POINT_COUNT;
				end
			end else begin
				do_eop = 1'b1;
			end
		end

		// End of a part: multi geometries count parts down.
		if (do_eop) begin
			if (top_type_q == GT_MULTILINE || top_type_q == GT_MULTIPOLY) begin
				part_ctr_d   = part_ctr_q + 32'd1;
				parts_left_d = parts_left_q - 32'd1;
				if (parts_left_q == 32'd1) begin
					do_complete = 1'b1;
				end else begin
					phase_d = PH_SUB_ORDER;
				end
			end else begin
				do_complete = 1'b1;
			end
		end

		if (do_fail || do_complete) begin
			finished_d = 1'b1;
			phase_d    = PH_IDLE;
		end

		// Results carry the header fields as they stand before any rearm.
		em_type = top_type_d;
		em_srid = top_srid_d;

		// The last byte of a buffer rearms the parser.
		if (proc && in_word.end_of_buffer) begin
			e_eob         = !finished_d;
			phase_d       = PH_TOP_ORDER;
			bif_d         = '0;
			acc_d         = '0;
			held_x_d      = '0;
			top_type_d    = GT_NONE;
			top_srid_d    = '0;
			parts_left_d  = '0;
			rings_left_d  = '0;
			points_left_d = '0;
			part_ctr_d    = '0;
			ring_ctr_d    = '0;
			point_ctr_d   = '0;
			finished_d    = 1'b0;
		end

		// Result words in the order they arise.
		res = '0;
		n   = 2'd0;
		if (e_point) begin
			res.item[n[0]] = mk_res(EV_POINT, em_type, em_srid, held_x_q, v,
				part_ctr_q, ring_ctr_q, point_ctr_q, 2'd0);
			n = n + 2'd1;
		end
		if (e_header) begin
			res.item[n[0]] = mk_res(EV_HEADER, em_type, em_srid, '0, '0, '0, '0, '0, 2'd0);
			n = n + 2'd1;
		end
		if (do_complete || do_fail) begin
			res.item[n[0]] = mk_res(do_fail ? EV_ERROR : EV_COMPLETE, em_type, em_srid,
				'0, '0, '0, '0, '0, do_fail ? fail_code : 2'd0);
			n = n + 2'd1;
		end
		if (e_eob) begin
			res.item[n[0]] = mk_res(EV_ERROR, em_type, em_srid, '0, '0, '0, '0, '0,
				ERR_TRUNCATED);
			n = n + 2'd1;
		end
		res.count = n;
		if (n != 2'd0) begin
			res.item[~n[0]].last_of_run = 1'b1;
		end
	end

	// Parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TOP_ORDER;
			bif_q         <= '0;
			acc_q         <= '0;
			top_type_q    <= GT_NONE;
			top_srid_q    <= '0;
			parts_left_q  <= '0;
			rings_left_q  <= '0;
			points_left_q <= '0;
			part_ctr_q    <= '0;
			ring_ctr_q    <= '0;
			point_ctr_q   <= '0;
			finished_q    <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			bif_q         <= bif_d;
			acc_q         <= acc_d;
			top_type_q    <= top_type_d;
			top_srid_q    <= top_srid_d;
			parts_left_q  <= parts_left_d;
			rings_left_q  <= rings_left_d;
			points_left_q <= points_left_d;
			part_ctr_q    <= part_ctr_d;
			ring_ctr_q    <= ring_ctr_d;
			point_ctr_q   <= point_ctr_d;
			finished_q    <= finished_d;
		end
	end

	// The x coordinate waits here for its y.
	always_ff @(posedge clk) begin
		held_x_q <= held_x_d;
	end

	// A finished frame always sits in the idle phase, and only there.
	a_finished_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q == (phase_q == PH_IDLE))
		else $error("finished flag and idle phase disagree");

	// The last byte of a buffer always rearms the parser.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		proc && in_word.end_of_buffer |=> phase_q == PH_TOP_ORDER && !finished_q)
		else $error("parser did not rearm after the last byte");

	// An error word never has another word after it from the same byte.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.count == 2'd2 |-> res.item[0].event_res != EV_ERROR)
		else $error("error word followed by another word");

	// Nothing is produced without a byte.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!proc |-> res.count == 2'd0)
		else $error("result word without an input byte");

endmodule

### hw/rtl/wkbp_fifo.sv
module wkbp_fifo import wkbp_pkg::*; #(
	parameter int DEPTH = RES_FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t push,
	output logic      room,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_word_t     mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW-1:0] wr_p1;
	logic [PW-1:0] wr_p2;
	logic [CW-1:0] cnt_q;
	logic          pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Queue status; a byte needs room for two words before it is taken.
	assign wr_p1     = next_ptr(wr_q);
	assign wr_p2     = next_ptr(wr_p1);
	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	assign room      = (cnt_q <= CW'(DEPTH - 2));
	assign res_data  = mem[rd_q];

	// Word storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.item[0];
		end
		if (push.count == 2'd2) begin
			mem[wr_p1] <= push.item[1];
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (push.count)
				2'd1:    wr_q <= wr_p1;
				2'd2:    wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			cnt_q <= cnt_q + CW'(push.count) - CW'(pop);
		end
	end

	// Words only arrive when two free slots were promised.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> cnt_q <= CW'(DEPTH - 2))
		else $error("result words pushed without room");

	// The fill count never passes the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue overflow");

endmodule

### hw/rtl/wkb_geometry_stream_parser.sv
// Streaming parser for little-endian extended WKB geometries. One byte of the
// buffer enters per src word, with end_of_buffer set on the buffer's last byte;
// each byte yields zero, one or two result words (header, point, complete or
// error) on the res channel, the last word of a byte flagged by last_of_run.
// The parser takes one byte every cycle while the result queue has room: the
// byte sits in an input register, and combinational decode logic updates the
// parse state and writes the byte's words into a small result queue, read out on
// res. Input stalls only when the result queue has fewer than two free
// slots, which happens when the res side stalls or when bytes that yield two
// words come faster than one word per cycle drains. Bytes after completion or
// an error are dropped until the buffer's last byte, which rearms the parser.
module wkb_geometry_stream_parser import wkbp_pkg::*; #(
	parameter int RES_FIFO_DEPTH = RES_FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_word_t src_data,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_data
);

	logic      valid_s1;
	src_word_t src_s1;
	logic      room;
	logic      proc;
	res_push_t push;

	// A registered byte is decoded once the queue can take its words.
	assign proc      = valid_s1 && room;
	assign src_stall = valid_s1 && !room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			src_s1 <= src_data;
		end
	end

	wkbp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc    (proc),
		.in_word (src_s1),
		.res     (push)
	);

	wkbp_fifo #(
		.DEPTH (RES_FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

### tb/testbench.sv
module testbench;
	import wkbp_pkg::*;

	typedef enum {PACE_NONE, PACE_SRC, PACE_RES, PACE_BOTH} pace_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	src_word_t src_data = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_word_t res_data;

	pace_t       pace = PACE_NONE;
	src_word_t   byte_stream[$];
	logic [7:0]  frame_bytes[$];
	res_word_t   awaited_events[$];
	res_word_t   step_words[$];
	int          words_queued = 0;
	int          failures = 0;
	logic [2:0]  geo_kinds [5] = '{GT_POINT, GT_LINE, GT_POLYGON, GT_MULTILINE, GT_MULTIPOLY};

	// Decoder state of the expected-result predictor.
	phase_t      dec_phase = PH_TOP_ORDER;
	logic [2:0]  dec_byte;
	logic [63:0] dec_acc;
	logic [63:0] dec_xhold;
	logic [2:0]  dec_type;
	logic [31:0] dec_srid;
	logic        dec_sub_srid;
	logic [31:0] dec_parts_left;
	logic [31:0] dec_rings_left;
	logic [31:0] dec_points_left;
	logic [31:0] dec_part_no;
	logic [31:0] dec_ring_no;
	logic [31:0] dec_point_no;
	logic        dec_done;

	wkb_geometry_stream_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always #2 clk = ~clk;

	// Return the decoder to its state after reset.
	task automatic clear_decoder();
		dec_phase = PH_TOP_ORDER;
		dec_byte = '0;
		dec_acc = '0;
		dec_xhold = '0;
		dec_type = GT_NONE;
		dec_srid = '0;
		dec_sub_srid = 1'b0;
		dec_parts_left = '0;
		dec_rings_left = '0;
		dec_points_left = '0;
		dec_part_no = '0;
		dec_ring_no = '0;
		dec_point_no = '0;
		dec_done = 1'b0;
	endtask

	function automatic logic known_code(input logic [15:0] code);
		return code == 16'(GT_POINT) || code == 16'(GT_LINE) || code == 16'(GT_POLYGON) ||
			code == 16'(GT_MULTILINE) || code == 16'(GT_MULTIPOLY);
	endfunction

	// Type that every part of the current multi geometry must carry.
	function automatic logic [2:0] part_code();
		return (dec_type == GT_MULTILINE) ? GT_LINE : GT_POLYGON;
	endfunction

	task automatic put_event(input logic [1:0] ev, input logic [63:0] x, input logic [63:0] y,
		input logic [31:0] pi, input logic [31:0] ri, input logic [31:0] qi,
		input logic [1:0] ec);
		res_word_t r;
		r.event_res = ev;
		r.geometry_type = dec_type;
		r.srid_value = dec_srid;
		r.x_bits = x;
		r.y_bits = y;
		r.part_index = pi;
		r.ring_index = ri;
		r.point_index = qi;
		r.error_code = ec;
		r.last_of_run = 1'b0;
		step_words.insert(step_words.size(), r);
	endtask

	task automatic abort_frame(input logic [1:0] ec);
		put_event(EV_ERROR, '0, '0, '0, '0, '0, ec);
		dec_done = 1'b1;
		dec_phase = PH_IDLE;
	endtask

	task automatic finish_frame();
		put_event(EV_COMPLETE, '0, '0, '0, '0, '0, '0);
		dec_done = 1'b1;
		dec_phase = PH_IDLE;
	endtask

	task automatic enter_body(input logic [2:0] code);
		case (code)
			GT_POINT:   dec_phase = PH_X;
			GT_LINE:    dec_phase = PH_POINT_COUNT;
			GT_POLYGON: dec_phase = PH_RING_COUNT;
			default:    dec_phase = PH_PART_COUNT;
		endcase
	endtask

	task automatic close_part();
		if (dec_type == GT_MULTILINE || dec_type == GT_MULTIPOLY) begin
			dec_part_no++;
			dec_parts_left--;
			if (dec_parts_left == 0) finish_frame();
			else dec_phase = PH_SUB_ORDER;
		end else begin
			finish_frame();
		end
	endtask

	task automatic close_line();
		if (dec_type == GT_POLYGON || dec_type == GT_MULTIPOLY) begin
			dec_ring_no++;
			dec_rings_left--;
			if (dec_rings_left == 0) close_part();
			else dec_phase = PH_POINT_COUNT;
		end else begin
			close_part();
		end
	endtask

	// Feed one accepted byte to the decoder and queue the words it should produce.
	task automatic decode_byte(input src_word_t w);
		logic [63:0] v;
		logic [31:0] wd;
		logic [15:0] code;
		logic        flag;
		int          flen;
		res_word_t   r;
		step_words.delete();
		if (!dec_done && dec_phase != PH_IDLE) begin
			if (dec_phase == PH_TOP_ORDER || dec_phase == PH_SUB_ORDER) flen = 1;
			else if (dec_phase == PH_X || dec_phase == PH_Y) flen = 8;
			else flen = 4;
			dec_acc = dec_acc | (64'(w.data_byte) << (8 * dec_byte));
			if (int'(dec_byte) + 1 >= flen) begin
				v = dec_acc;
				dec_acc = '0;
				dec_byte = '0;
				wd = v[31:0];
				code = wd[15:0];
				flag = wd[SRID_FLAG_BIT];
				case (dec_phase)
					PH_TOP_ORDER, PH_SUB_ORDER: begin
						if (v[7:0] != BYTE_ORDER_LE) abort_frame(ERR_BYTE_ORDER);
						else if (dec_phase == PH_TOP_ORDER) dec_phase = PH_TOP_TYPE;
						else dec_phase = PH_SUB_TYPE;
					end
					PH_TOP_TYPE: begin
						if (!known_code(code)) begin
							abort_frame(ERR_UNKNOWN);
						end else begin
							dec_type = code[2:0];
							if (flag) begin
								dec_phase = PH_TOP_SRID;
							end else begin
								put_event(EV_HEADER, '0, '0, '0, '0, '0, '0);
								enter_body(dec_type);
							end
						end
					end
					PH_TOP_SRID: begin
						dec_srid = wd;
						put_event(EV_HEADER, '0, '0, '0, '0, '0, '0);
						enter_body(dec_type);
					end
					PH_SUB_TYPE: begin
						if (code != 16'(part_code())) begin
							abort_frame(known_code(code) ? ERR_NESTED_TYPE : ERR_UNKNOWN);
						end else begin
							dec_sub_srid = flag;
							if (flag) dec_phase = PH_SUB_SRID;
							else enter_body(part_code());
						end
					end
					PH_SUB_SRID: enter_body(part_code());
					PH_PART_COUNT: begin
						dec_parts_left = wd;
						dec_part_no = '0;
						if (wd == 0) finish_frame();
						else dec_phase = PH_SUB_ORDER;
					end
					PH_RING_COUNT: begin
						dec_rings_left = wd;
						dec_ring_no = '0;
						if (wd == 0) close_part();
						else dec_phase = PH_POINT_COUNT;
					end
					PH_POINT_COUNT: begin
						dec_points_left = wd;
						dec_point_no = '0;
						if (wd == 0) close_line();
						else dec_phase = PH_X;
					end
					PH_X: begin
						dec_xhold = v;
						dec_phase = PH_Y;
					end
					PH_Y: begin
						put_event(EV_POINT, dec_xhold, v, dec_part_no, dec_ring_no, dec_point_no, '0);
						if (dec_type == GT_POINT) begin
							finish_frame();
						end else begin
							dec_point_no++;
							dec_points_left--;
							if (dec_points_left == 0) close_line();
							else dec_phase = PH_X;
						end
					end
					default: dec_phase = PH_IDLE;
				endcase
			end else begin
				dec_byte++;
			end
		end
		// The buffer's last byte flags truncation and rearms the parser.
		if (w.end_of_buffer) begin
			if (!dec_done) abort_frame(ERR_TRUNCATED);
			clear_decoder();
		end
		if (step_words.size() > 0) begin
			r = step_words[step_words.size() - 1];
			r.last_of_run = 1'b1;
			step_words[step_words.size() - 1] = r;
		end
		foreach (step_words[i]) awaited_events.insert(awaited_events.size(), step_words[i]);
	endtask

	function automatic int unsigned idle_pct(input bit rx_side);
		case (pace)
			PACE_SRC:  return rx_side ? 0 : 87;
			PACE_RES:  return rx_side ? 87 : 0;
			PACE_BOTH: return 28;
			default:   return 0;
		endcase
	endfunction

	function automatic string word_str(input res_word_t r);
		return $sformatf("ev=%0d type=%0d srid=%0d x=%h y=%h part=%0d ring=%0d pt=%0d err=%0d last=%0d",
			r.event_res, r.geometry_type, r.srid_value, r.x_bits, r.y_bits,
			r.part_index, r.ring_index, r.point_index, r.error_code, r.last_of_run);
	endfunction

	// Encoding helpers: bytes go little-endian into the frame under construction.
	task automatic put8(input logic [7:0] b);
		frame_bytes.insert(frame_bytes.size(), b);
	endtask

	task automatic put32(input logic [31:0] v);
		for (int i = 0; i < 4; i++) put8(v[8 * i +: 8]);
	endtask

	task automatic put64(input logic [63:0] v);
		put32(v[31:0]);
		put32(v[63:32]);
	endtask

	function automatic logic [63:0] coord();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic put_header(input logic [15:0] code, input bit with_srid, input logic [31:0] srid);
		logic [31:0] tw;
		tw = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hDFFF_0000) : 32'h0;
		tw[15:0] = code;
		tw[SRID_FLAG_BIT] = with_srid;
		put8(BYTE_ORDER_LE);
		put32(tw);
		if (with_srid) put32(srid);
	endtask

	task automatic put_run(input int n);
		put32(32'(n));
		repeat (n) begin
			put64(coord());
			put64(coord());
		end
	endtask

	task automatic put_rings(input int n);
		put32(32'(n));
		repeat (n) put_run($urandom_range(0, 3));
	endtask

	// Queue the frame, cut to cut bytes when cut is positive and below its size; end_of_buffer marks its last byte.
	task automatic send_frame(input int cut);
		src_word_t w;
		int        n;
		n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			w.data_byte = frame_bytes[i];
			w.end_of_buffer = (i == n - 1);
			byte_stream.insert(byte_stream.size(), w);
		end
		words_queued += n;
		frame_bytes.delete();
	endtask

	task automatic drain_input();
		while (byte_stream.size() > 0 || src_valid) @(negedge clk);
	endtask

	// Source driver: offers queued bytes and predicts results on each accepted word.
	always @(posedge clk) begin
		logic      nxt_valid;
		src_word_t nxt_data;
		if (arst_n) begin
			nxt_valid = src_valid;
			nxt_data = src_data;
			if (src_valid && !src_stall) begin
				decode_byte(src_data);
				void'(byte_stream.pop_front());
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && byte_stream.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
				nxt_valid = 1'b1;
				nxt_data = byte_stream[0];
			end
			src_valid <= nxt_valid;
			src_data <= nxt_data;
		end
	end

	// Result monitor: checks each accepted word against the oldest expectation.
	always @(posedge clk) begin
		res_word_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (awaited_events.size() == 0) begin
					failures++;
					if (failures <= 10) $display("unexpected result word: %s", word_str(res_data));
				end else begin
					want = awaited_events.pop_front();
					if (res_data !== want) begin
						failures++;
						if (failures <= 10) begin
							$display("result mismatch:");
							$display("  expected %s", word_str(want));
							$display("  actual   %s", word_str(res_data));
						end
					end
				end
			end
			res_stall <= ($urandom_range(99) < idle_pct(1'b1));
		end
	end

	initial begin
		pace_t       order [4];
		logic [2:0]  kind;
		logic [15:0] sub;
		int          goal;
		int          r;
		int          cut;
		int          idx;
		int          nparts;
		int          wait_cycles;
		order = '{PACE_NONE, PACE_SRC, PACE_RES, PACE_BOTH};
		clear_decoder();
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed frames, sent with no idling.
		// Point with coordinate extremes.
		put_header(16'(GT_POINT), 1'b0, '0);
		put64('0);
		put64('1);
		send_frame(0);
		// Point with every ignored type bit set, most negative SRID and trailing bytes.
		put8(BYTE_ORDER_LE);
		put32(32'hFFFF_0001);
		put32(32'h8000_0000);
		put64('1);
		put64('0);
		put8(8'hFF);
		put8(8'h00);
		send_frame(0);
		// Bad byte order, alone and followed by ignored bytes.
		put8(8'h00);
		send_frame(0);
		put8(8'hFF);
		put32(32'h1);
		send_frame(0);
		// Unknown top-level type codes.
		put8(BYTE_ORDER_LE);
		put32(32'h0000_FFFF);
		send_frame(0);
		put8(BYTE_ORDER_LE);
		put32(32'h0000_0004);
		put8(8'h55);
		send_frame(0);
		// Empty line with the largest SRID: completion on the count's last byte.
		put_header(16'(GT_LINE), 1'b1, 32'h7FFF_FFFF);
		put32('0);
		send_frame(0);
		// Polygon with an empty outer ring and a one-point inner ring.
		put_header(16'(GT_POLYGON), 1'b0, '0);
		put32(32'd2);
		put_run(0);
		put_run(1);
		send_frame(0);
		// Multiline holding a polygon part.
		put_header(16'(GT_MULTILINE), 1'b0, '0);
		put32(32'd1);
		put_header(16'(GT_POLYGON), 1'b0, '0);
		send_frame(0);
		// Multipolygon with an unknown nested code, then with a bad nested byte order.
		put_header(16'(GT_MULTIPOLY), 1'b1, 32'hFFFF_FFFF);
		put32(32'd1);
		put_header(16'd4, 1'b0, '0);
		send_frame(0);
		put_header(16'(GT_MULTIPOLY), 1'b0, '0);
		put32(32'd1);
		put8(8'h02);
		send_frame(0);
		// Multipolygon with a nested SRID, then an empty one.
		put_header(16'(GT_MULTIPOLY), 1'b1, 32'd4326);
		put32(32'd1);
		put_header(16'(GT_POLYGON), 1'b1, 32'd3857);
		put32(32'd2);
		put_run(2);
		put_run(1);
		send_frame(0);
		put_header(16'(GT_MULTIPOLY), 1'b0, '0);
		put32('0);
		send_frame(0);
		// Buffer ends on the header: header word then truncation from one byte.
		put_header(16'(GT_LINE), 1'b0, '0);
		send_frame(0);
		// Buffer of a single byte.
		put8(BYTE_ORDER_LE);
		send_frame(0);
		// Buffer ends on a point with another part still to come.
		put_header(16'(GT_MULTILINE), 1'b0, '0);
		put32(32'd2);
		put_header(16'(GT_LINE), 1'b0, '0);
		put_run(1);
		cut = frame_bytes.size();
		put_header(16'(GT_LINE), 1'b0, '0);
		put_run(2);
		send_frame(cut);
		drain_input();

		// Random frames: mostly well formed, some cut short, corrupted or plain noise.
		foreach (order[p]) begin
			pace = order[p];
			goal = words_queued + 300;
			while (words_queued < goal) begin
				kind = geo_kinds[$urandom_range(0, 4)];
				put_header(16'(kind), bit'($urandom_range(0, 1)), $urandom);
				case (kind)
					GT_POINT: begin
						put64(coord());
						put64(coord());
					end
					GT_LINE:    put_run($urandom_range(0, 3));
					GT_POLYGON: put_rings($urandom_range(0, 2));
					default: begin
						nparts = $urandom_range(0, 2);
						put32(32'(nparts));
						repeat (nparts) begin
							sub = (kind == GT_MULTILINE) ? 16'(GT_LINE) : 16'(GT_POLYGON);
							if ($urandom_range(0, 11) == 0) sub = 16'($urandom_range(0, 7));
							put_header(sub, bit'($urandom_range(0, 1)), $urandom);
							if (kind == GT_MULTILINE) put_run($urandom_range(0, 3));
							else put_rings($urandom_range(0, 2));
						end
					end
				endcase
				r = $urandom_range(0, 99);
				cut = 0;
				if (r < 65) begin
					if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) put8(8'($urandom));
				end else if (r < 80) begin
					cut = $urandom_range(1, frame_bytes.size() - 1);
				end else if (r < 92) begin
					idx = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8) :
						$urandom_range(0, frame_bytes.size() - 1);
					frame_bytes[idx] = 8'($urandom);
				end else begin
					frame_bytes.delete();
					repeat ($urandom_range(1, 12)) put8(8'($urandom));
				end
				send_frame(cut);
			end
			drain_input();
		end

		// Let the last results drain, then report.
		wait_cycles = 0;
		while (awaited_events.size() > 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (awaited_events.size() > 0) begin
			failures++;
			$display("%0d expected result words never arrived", awaited_events.size());
		end
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
